@@ sv/mas_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mas_pkg
// Types and constants shared by the Modbus ASCII slave handler files.
// ----------------------------------------------------------------------------
package mas_pkg;

  localparam int RX_DEPTH_DEF = 32;
  // buffer positions the frame decoder looks at
  localparam int HEX_SPAN     = 10;

  localparam logic [1:0] REQ_CHAR   = 2'd0;
  localparam logic [1:0] REQ_ANALOG = 2'd1;
  localparam logic [1:0] REQ_INPUTS = 2'd2;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_CR    = 8'd13;

  localparam logic [7:0] FN_READ_COILS  = 8'h01;
  localparam logic [7:0] FN_READ_INPUTS = 8'h02;
  localparam logic [7:0] FN_READ_REGS   = 8'h03;
  localparam logic [7:0] FN_WRITE_COIL  = 8'h05;

  localparam logic [7:0] COIL_ON       = 8'hff;
  localparam logic [7:0] BYTE_COUNT_1  = 8'h01;
  localparam logic [7:0] BYTE_COUNT_8  = 8'h08;
  localparam logic [7:0] DEV_ADDR_RST  = 8'd1;
  localparam logic [1:0] DIN_RST       = 2'd3;

  localparam logic [3:0] LEN_READ_BITS = 4'd4;
  localparam logic [3:0] LEN_READ_REGS = 4'd11;
  localparam logic [3:0] LEN_WRITE     = 4'd6;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_char;
    logic [1:0] reg_index;
    logic [9:0] reg_value;
    logic [1:0] button_bits;
  } req_t;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic       resp_last;
    logic [3:0] coil_state;
  } resp_t;

endpackage
`default_nettype wire

@@ sv/mas_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mas_if
// Valid/ready channels for requests and response bytes.
// ----------------------------------------------------------------------------
interface mas_req_if import mas_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mas_resp_if import mas_pkg::*; ();
  logic  valid;
  logic  ready;
  resp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/mas_rxbuf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mas_rxbuf
// Frame character memory with a registered read that returns the hex digit
// value of the stored character; entries never written read as zero.
// ----------------------------------------------------------------------------
module mas_rxbuf
  import mas_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(RX_DEPTH)-1:0] wr_addr,
  input  wire logic [7:0]                  wr_data,
  input  wire logic [$clog2(RX_DEPTH)-1:0] rd_addr,
  output logic      [3:0]                  rd_digit
);

  localparam int AW     = $clog2(RX_DEPTH);
  localparam int SPAN_W = $clog2(HEX_SPAN);

  logic [7:0]          mem [RX_DEPTH];
  logic [HEX_SPAN-1:0] seen;
  logic [7:0]          rd_q;
  logic                rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en && (wr_addr < AW'(HEX_SPAN))) begin
        seen[wr_addr[SPAN_W-1:0]] <= 1'b1;
      end
      rd_hit <= (rd_addr < AW'(HEX_SPAN)) && seen[rd_addr[SPAN_W-1:0]];
    end
  end

  always_comb begin
    rd_digit = 4'd0;
    if (rd_hit) begin
      if (rd_q >= "0" && rd_q <= "9") begin
        rd_digit = 4'(rd_q - "0");
      end else if (rd_q >= "A" && rd_q <= "F") begin
        rd_digit = 4'(rd_q - "A" + 8'd10);
      end else if (rd_q >= "a" && rd_q <= "f") begin
        rd_digit = 4'(rd_q - "a" + 8'd10);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/modbus_ascii_slave_handler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_ascii_slave_handler
// Modbus ASCII slave front end producing a binary response byte stream.
// ----------------------------------------------------------------------------
// Characters, analog register updates and discrete input updates are taken
// one per cycle while no frame is being answered. A CR that closes a frame
// starts the responder: it reads eight characters of the frame memory, one a
// cycle through its single registered read port, then decides on the frame and
// loads one response byte a cycle into the output register while the sink
// takes them (4, 6 or 11 bytes). Input is held off from the CR until the last
// response byte is in the output register, or until the decision if the frame
// is for another address or has an unsupported function code.
module modbus_ascii_slave_handler
  import mas_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  mas_req_if.sink         req,
  mas_resp_if.source      resp,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  localparam int AW = $clog2(RX_DEPTH);
  localparam int CW = $clog2(RX_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]    state;
  logic [7:0]    dev_addr;
  logic          in_frame;
  logic [CW-1:0] char_count;
  logic [3:0]    coil_bits;
  logic [1:0]    din;
  logic [9:0]    areg [4];
  logic [3:0]    rd_step;
  logic [31:0]   nib;
  logic [7:0]    func;
  logic [3:0]    resp_len;
  logic [3:0]    byte_idx;
  logic          out_valid;
  resp_t         out_data;

  logic          take;
  logic          wr_en;
  logic [3:0]    rd_pos;
  logic [3:0]    rd_digit;
  logic          load;
  logic          is_last;
  logic [7:0]    cur_byte;
  logic [7:0]    f_addr;
  logic [7:0]    f_func;
  logic [7:0]    f_coil;
  logic [7:0]    f_value;
  logic [3:0]    coil_mask;

  assign req.ready  = (state == S_IDLE);
  assign take       = req.valid && req.ready;
  assign resp.valid = out_valid;
  assign resp.data  = out_data;

  assign wr_en = take && (req.data.req_type == REQ_CHAR) && in_frame &&
                 (req.data.rx_char != CH_CR) && (char_count < CW'(RX_DEPTH));

  // positions 0-3 then 6-9
  assign rd_pos = (rd_step < 4'd4) ? rd_step : rd_step + 4'd2;

  mas_rxbuf #(
    .RX_DEPTH (RX_DEPTH)
  ) u_rxbuf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (char_count[AW-1:0]),
    .wr_data  (req.data.rx_char),
    .rd_addr  (AW'(rd_pos)),
    .rd_digit (rd_digit)
  );

  assign f_addr    = nib[31:24];
  assign f_func    = nib[23:16];
  assign f_coil    = nib[15:8];
  assign f_value   = nib[7:0];
  assign coil_mask = 4'b0001 << f_coil[1:0];

  assign load    = (state == S_EMIT) && (!out_valid || resp.ready);
  assign is_last = (byte_idx == resp_len - 4'd1);

  always_comb begin
    cur_byte = 8'h00;
    case (byte_idx)
      4'd0: cur_byte = dev_addr;
      4'd1: cur_byte = func;
      4'd2: begin
        case (func)
          FN_READ_REGS:  cur_byte = BYTE_COUNT_8;
          FN_WRITE_COIL: cur_byte = 8'h00;
          default:       cur_byte = BYTE_COUNT_1;
        endcase
      end
      4'd3: begin
        case (func)
          FN_READ_COILS:  cur_byte = {4'd0, coil_bits};
          FN_READ_INPUTS: cur_byte = {6'd0, din};
          FN_READ_REGS:   cur_byte = {6'd0, areg[0][9:8]};
          default:        cur_byte = f_coil;
        endcase
      end
      4'd4:    cur_byte = (func == FN_READ_REGS) ? areg[0][7:0] : f_value;
      4'd5:    cur_byte = (func == FN_READ_REGS) ? {6'd0, areg[1][9:8]} : 8'h00;
      4'd6:    cur_byte = areg[1][7:0];
      4'd7:    cur_byte = {6'd0, areg[2][9:8]};
      4'd8:    cur_byte = areg[2][7:0];
      4'd9:    cur_byte = {6'd0, areg[3][9:8]};
      4'd10:   cur_byte = areg[3][7:0];
      default: cur_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dev_addr   <= DEV_ADDR_RST;
      in_frame   <= 1'b0;
      char_count <= '0;
      coil_bits  <= 4'd0;
      din        <= DIN_RST;
      areg[0]    <= '0;
      areg[1]    <= '0;
      areg[2]    <= '0;
      areg[3]    <= '0;
      rd_step    <= 4'd0;
      byte_idx   <= 4'd0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dev_addr <= cfg_wr_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            case (req.data.req_type)
              REQ_ANALOG: areg[req.data.reg_index] <= req.data.reg_value;
              REQ_INPUTS: din <= req.data.button_bits;
              REQ_CHAR: begin
                if (!in_frame) begin
                  if (req.data.rx_char == CH_COLON) begin
                    in_frame   <= 1'b1;
                    char_count <= '0;
                  end
                end else if (req.data.rx_char == CH_CR) begin
                  in_frame   <= 1'b0;
                  char_count <= '0;
                  rd_step    <= 4'd0;
                  state      <= S_READ;
                end else if (wr_en) begin
                  char_count <= char_count + CW'(1);
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          rd_step <= rd_step + 4'd1;
          if (rd_step == 4'd8) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          func     <= f_func;
          byte_idx <= 4'd0;
          if (f_addr == dev_addr) begin
            case (f_func)
              FN_READ_COILS, FN_READ_INPUTS: begin
                resp_len <= LEN_READ_BITS;
                state    <= S_EMIT;
              end
              FN_READ_REGS: begin
                resp_len <= LEN_READ_REGS;
                state    <= S_EMIT;
              end
              FN_WRITE_COIL: begin
                resp_len <= LEN_WRITE;
                state    <= S_EMIT;
                if (f_coil < 8'd4) begin
                  if (f_value == COIL_ON) begin
                    coil_bits <= coil_bits | coil_mask;
                  end else begin
                    coil_bits <= coil_bits & ~coil_mask;
                  end
                end
              end
              default: state <= S_IDLE;
            endcase
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (load) begin
            byte_idx <= byte_idx + 4'd1;
            if (is_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // digit shift register and output payload
  always_ff @(posedge clk) begin
    if (state == S_READ && rd_step != 4'd0) begin
      nib <= {nib[27:0], rd_digit};
    end
    if (load) begin
      out_data.resp_byte  <= cur_byte;
      out_data.resp_last  <= is_last;
      out_data.coil_state <= coil_bits;
    end
  end

  a_cr_starts_read: assert property (@(posedge clk) disable iff (rst)
    take && (req.data.req_type == REQ_CHAR) && in_frame && (req.data.rx_char == CH_CR)
    |=> (state == S_READ) && !in_frame && (rd_step == 4'd0))
    else $error("frame close did not start the responder");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= CW'(RX_DEPTH))
    else $error("character count past buffer depth");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (byte_idx < resp_len))
    else $error("response byte index past response length");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    load && is_last |=> (state == S_IDLE) && out_valid && out_data.resp_last)
    else $error("last response byte did not end the response");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (rd_step <= 4'd8))
    else $error("frame read step out of range");

endmodule
`default_nettype wire
